### src/jdcal_pkg.sv
// Shared constants and tables for the Julian day to calendar date pipeline.
package jdcal_pkg;

    // Register stages from input capture to output register
    localparam int JDC_STAGES = 10;

    // floor(n / 10) = (n * RECIP_TEN) >> 31, exact for n < 2^30
    localparam logic [27:0] RECIP_TEN      = 28'd214748365;
    localparam logic [3:0]  ROUND_TENTHS   = 4'd5;

    // Gregorian century correction: floor((4*jd + ALPHA_OFFSET) / DAYS_400Y)
    localparam logic [16:0] ALPHA_OFFSET   = 17'd128179;
    localparam logic [14:0] RECIP_400Y     = 15'd29398;      // floor(2^32 / 146097)
    localparam logic [17:0] DAYS_400Y      = 18'd146097;

    // Year estimate: floor((4*b - LEAP_BIAS) / DAYS_4Y)
    localparam logic [10:0] MARCH_BASE     = 11'd1486;
    localparam logic [9:0]  LEAP_BIAS      = 10'd489;
    localparam logic [21:0] RECIP_4Y       = 22'd2939744;    // floor(2^32 / 1461)
    localparam logic [10:0] DAYS_4Y        = 11'd1461;

    // Month estimate: floor(100*x / MONTH_SPAN_X100)
    localparam logic [19:0] RECIP_MONTH    = 20'd548000;     // 100 * floor(2^24 / 3061)
    localparam logic [11:0] MONTH_SPAN_X100 = 12'd3061;
    localparam logic [6:0]  HUNDRED        = 7'd100;

    // Year mapping
    localparam logic [16:0] YEAR_EPOCH     = 17'd4716;
    localparam logic [16:0] CENTURY_BASE   = 17'd1900;
    localparam logic [16:0] YEAR_SAT       = 17'd16383;

    // floor(3061 * e / 100): first day offset of month index e
    function automatic logic [8:0] month_start(input logic [3:0] e);
        logic [8:0] v;
        case (e)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd30;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd183;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd336;
            4'd12:   v = 9'd367;
            4'd13:   v = 9'd397;
            4'd14:   v = 9'd428;
            4'd15:   v = 9'd459;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

### src/julian_day_to_calendar_date.sv
// Top level: Julian day count in tenths to Gregorian month, day and year.
//
// Usage:
//   Input channel (item_valid / item_stall) carries julian_day_tenths, a Julian
//   day number times ten; a tenths digit of 5 or more rounds up one day.
//   Output channel (date_valid / date_stall) carries month, day_of_month and
//   year_offset (year minus 1900 above 1900, else the year, floored at 0 and
//   saturating at the field maximum). One result beat per input beat, in order.
//   Pipeline: ten register stages, from input capture to output register.
//   Throughput: one beat per cycle unless stalled. Each stage holds at most one
//   constant multiply or one estimate-and-correct step of a constant division.
//   Stall: while date_valid is high and date_stall is high the whole pipe
//   holds and item_stall rises; nothing is dropped or repeated. Bubbles are
//   not squeezed out, so throughput returns as soon as the stall drops.
//   Reset: rst_n clears every valid bit at once; payload registers are not
//   reset and carry no meaning until their valid bit is set.
module julian_day_to_calendar_date
    import jdcal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [25:0] julian_day_tenths,
    output logic        date_valid,
    input  logic        date_stall,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [13:0] year_offset
);

    logic advance;

    jdcal_pipe_ctrl #(
        .Stages (JDC_STAGES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .date_valid (date_valid),
        .date_stall (date_stall),
        .advance    (advance)
    );

    // Stage 0: reciprocal multiply for the day / tenths split
    logic [25:0] raw0_reg;
    logic [22:0] q10_0_reg;
    logic [53:0] p10_next;

    // Stage 1: rounded day number
    logic [22:0] jd1_reg;
    logic [22:0] jd1_next;
    logic [25:0] q10x10;
    logic [25:0] rem10;

    // Stage 2: century estimate
    logic [22:0] jd2_reg;
    logic [24:0] u2_reg;
    logic [7:0]  qa_est2_reg;
    logic [24:0] u2_next;
    logic [39:0] pa_next;

    // Stage 3: corrected century count
    logic [22:0] jd3_reg;
    logic [7:0]  qa3_reg;
    logic [7:0]  qa3_next;
    logic [25:0] qa_prod;
    logic [25:0] qa_rem;

    // Stage 4: shifted day and year estimate
    logic [22:0] b4_reg;
    logic [24:0] v4_reg;
    logic [14:0] c_est4_reg;
    logic [22:0] b4_next;
    logic [24:0] v4_next;
    logic [46:0] pc_next;

    // Stage 5: corrected year count
    logic [22:0] b5_reg;
    logic [14:0] c5_reg;
    logic [14:0] c5_next;
    logic [25:0] c_prod;
    logic [25:0] c_rem;

    // Stage 6: day within the shifted year
    logic [8:0]  x6_reg;
    logic [14:0] c6_reg;
    logic [8:0]  x6_next;
    logic [25:0] d_prod;
    logic [22:0] d_days;
    logic [22:0] x_wide;

    // Stage 7: month estimate
    logic [8:0]  x7_reg;
    logic [14:0] c7_reg;
    logic [4:0]  e_est7_reg;
    logic [28:0] pe_next;

    // Stage 8: corrected month index
    logic [8:0]  x8_reg;
    logic [14:0] c8_reg;
    logic [3:0]  e8_reg;
    logic [4:0]  e8_next;
    logic [16:0] x100;
    logic [16:0] e_prod;
    logic [16:0] e_rem;

    // Stage 9: output register
    logic [3:0]  month_reg;
    logic [4:0]  dom_reg;
    logic [13:0] year_reg;
    logic [3:0]  month_next;
    logic [4:0]  dom_next;
    logic [13:0] year_next;
    logic [8:0]  dom_wide;
    logic signed [16:0] year_s;

    always_comb
    begin
        // Stage 0: day = tenths / 10 from the high product bits
        p10_next = 54'(julian_day_tenths) * 54'(RECIP_TEN);

        // Stage 1: tenths digit and round-half-up
        q10x10   = {q10_0_reg, 3'b000} + {2'b00, q10_0_reg, 1'b0};
        rem10    = raw0_reg - q10x10;
        jd1_next = q10_0_reg + {22'd0, (rem10[3:0] >= ROUND_TENTHS)};

        // Stage 2: estimate floor(u / 146097), low by at most one
        u2_next  = {jd1_reg, 2'b00} + 25'(ALPHA_OFFSET);
        pa_next  = 40'(u2_next) * 40'(RECIP_400Y);

        // Stage 3: correct the century estimate
        qa_prod  = 26'(qa_est2_reg) * 26'(DAYS_400Y);
        qa_rem   = {1'b0, u2_reg} - qa_prod;
        qa3_next = qa_est2_reg + {7'd0, (qa_rem >= 26'(DAYS_400Y))};

        // Stage 4: b = jd + qa - qa/4 + 1486, then estimate floor((4b - 489) / 1461)
        b4_next  = jd3_reg + 23'(qa3_reg) - 23'(qa3_reg[7:2]) + 23'(MARCH_BASE);
        v4_next  = {b4_next, 2'b00} - 25'(LEAP_BIAS);
        pc_next  = 47'(v4_next) * 47'(RECIP_4Y);

        // Stage 5: correct the year estimate
        c_prod   = 26'(c_est4_reg) * 26'(DAYS_4Y);
        c_rem    = {1'b0, v4_reg} - c_prod;
        c5_next  = c_est4_reg + {14'd0, (c_rem >= 26'(DAYS_4Y))};

        // Stage 6: days into the March-based year, always within 123..488
        d_prod   = 26'(c5_reg) * 26'(DAYS_4Y);
        d_days   = d_prod[25:2] > 24'(23'h7FFFFF) ? 23'h7FFFFF : d_prod[24:2];
        x_wide   = b5_reg - d_days;
        x6_next  = x_wide[8:0];

        // Stage 7: estimate floor(100x / 3061)
        pe_next  = 29'(x6_reg) * 29'(RECIP_MONTH);

        // Stage 8: correct the month estimate
        x100     = 17'(x7_reg) * 17'(HUNDRED);
        e_prod   = 17'(e_est7_reg) * 17'(MONTH_SPAN_X100);
        e_rem    = x100 - e_prod;
        e8_next  = e_est7_reg + {4'd0, (e_rem >= 17'(MONTH_SPAN_X100))};

        // Stage 9: day, month, year
        dom_wide = x8_reg - month_start(e8_reg);
        dom_next = dom_wide[4:0];
        if (e8_reg >= 4'd14)
        begin
            month_next = e8_reg - 4'd13;
        end
        else
        begin
            month_next = e8_reg - 4'd1;
        end
        year_s = $signed({2'b00, c8_reg}) - $signed(YEAR_EPOCH);
        if (month_next <= 4'd2)
        begin
            year_s = year_s + 17'sd1;
        end
        if (year_s > $signed(CENTURY_BASE))
        begin
            year_s = year_s - $signed(CENTURY_BASE);
        end
        if (year_s < 17'sd0)
        begin
            year_next = '0;
        end
        else if (year_s > $signed(YEAR_SAT))
        begin
            year_next = YEAR_SAT[13:0];
        end
        else
        begin
            year_next = year_s[13:0];
        end
    end

    // Payload moves on every advance; valid bits live in the controller
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            raw0_reg    <= julian_day_tenths;
            q10_0_reg   <= p10_next[53:31];

            jd1_reg     <= jd1_next;

            jd2_reg     <= jd1_reg;
            u2_reg      <= u2_next;
            qa_est2_reg <= pa_next[39:32];

            jd3_reg     <= jd2_reg;
            qa3_reg     <= qa3_next;

            b4_reg      <= b4_next;
            v4_reg      <= v4_next;
            c_est4_reg  <= pc_next[46:32];

            b5_reg      <= b4_reg;
            c5_reg      <= c5_next;

            x6_reg      <= x6_next;
            c6_reg      <= c5_reg;

            x7_reg      <= x6_reg;
            c7_reg      <= c6_reg;
            e_est7_reg  <= pe_next[28:24];

            x8_reg      <= x7_reg;
            c8_reg      <= c7_reg;
            e8_reg      <= e8_next[3:0];

            month_reg   <= month_next;
            dom_reg     <= dom_next;
            year_reg    <= year_next;
        end
    end

    assign month        = month_reg;
    assign day_of_month = dom_reg;
    assign year_offset  = year_reg;

endmodule

### src/jdcal_pipe_ctrl.sv
// Valid tracking and stall control for the date conversion pipeline.
module jdcal_pipe_ctrl
    import jdcal_pkg::*;
#(
    parameter int Stages = JDC_STAGES
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic item_stall,
    output logic date_valid,
    input  logic date_stall,
    output logic advance
);

    logic [Stages-1:0] valid_reg;
    logic [Stages-1:0] valid_next;

    // Freeze the whole pipe only while a finished beat waits at the output
    assign advance    = !valid_reg[Stages-1] || !date_stall;
    assign item_stall = !advance;
    assign date_valid = valid_reg[Stages-1];

    always_comb
    begin
        valid_next = {valid_reg[Stages-2:0], item_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> valid_reg[0])
        else $error("accepted beat did not enter the first stage");

    a_hold_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(valid_reg))
        else $error("valid bits moved while the pipe was frozen");

    a_shift_on_advance : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (valid_reg[Stages-1:1] == $past(valid_reg[Stages-2:0])))
        else $error("valid bits did not advance one stage");

    a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (date_valid && date_stall))
        else $error("input stalled without a waiting output beat");

endmodule
